>>> design/pmhd_pkg.sv
// Package for the peak meter hold and decay core.
// Holds field widths, register address codes, reset values and shared types.
// No dependencies.
package pmhd_pkg;

    localparam int CH_W         = 8;
    localparam int LEVEL_W      = 15;
    localparam int TICK_W       = 16;
    localparam int PROD_W       = 2 * TICK_W;
    localparam int DROP_SHIFT   = 8;
    localparam int DROP_W       = PROD_W - DROP_SHIFT;
    localparam int CHANNELS_DEF = 256;
    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;

    localparam logic [TICK_W-1:0]  DECAY_RST = 16'd64;
    localparam logic [TICK_W-1:0]  HOLD_RST  = 16'd1000;
    localparam logic [LEVEL_W-1:0] CLIP_RST  = 15'd13777;

    typedef enum logic [1:0] {
        REG_DECAY = 2'd0,
        REG_HOLD  = 2'd1,
        REG_CLIP  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0]  decay_per_tick;
        logic [TICK_W-1:0]  hold_ticks;
        logic [LEVEL_W-1:0] clip_threshold;
    } t_cfg;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] rms;
        logic [TICK_W-1:0]  timer;
        logic [LEVEL_W-1:0] held;
    } t_chan_state;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] rms;
        logic [TICK_W-1:0]  elapsed;
        logic [DROP_W-1:0]  drop;
    } t_item;

endpackage

>>> design/pmhd_ballistics.sv
// Per-item meter ballistics: level decay, peak hold timer and clip flags.
// Purely combinational; uses types from pmhd_pkg.
module pmhd_ballistics (
    input  pmhd_pkg::t_item       i_item,
    input  pmhd_pkg::t_chan_state i_prev,
    input  logic                  i_first,
    input  pmhd_pkg::t_cfg        i_cfg,
    output pmhd_pkg::t_chan_state o_next,
    output logic                  o_peak_clip,
    output logic                  o_rms_clip
);
    import pmhd_pkg::*;

    function automatic logic [LEVEL_W-1:0] sat_drop(input logic [LEVEL_W-1:0] lvl,
                                                    input logic [DROP_W-1:0]  drop);
        logic [DROP_W-1:0] wide;
        wide = DROP_W'(lvl);
        return (wide > drop) ? LEVEL_W'(wide - drop) : '0;
    endfunction

    function automatic logic [LEVEL_W-1:0] fall_level(input logic [LEVEL_W-1:0] prev,
                                                      input logic [LEVEL_W-1:0] now,
                                                      input logic [DROP_W-1:0]  drop);
        logic [LEVEL_W-1:0] d;
        d = sat_drop(prev, drop);
        if (now >= prev) begin
            return now;
        end
        return (d > now) ? d : now;
    endfunction

    logic [LEVEL_W-1:0] w_sp;
    logic [LEVEL_W-1:0] w_sr;
    logic [TICK_W-1:0]  w_ht;

    always_comb begin
        w_sp = fall_level(i_prev.peak, i_item.peak, i_item.drop);
        w_sr = fall_level(i_prev.rms, i_item.rms, i_item.drop);
        w_ht = (i_prev.timer > i_item.elapsed) ? (i_prev.timer - i_item.elapsed) : '0;
        if (i_first) begin
            o_next.peak  = i_item.peak;
            o_next.rms   = i_item.rms;
            o_next.held  = i_item.peak;
            o_next.timer = i_cfg.hold_ticks;
        end else if (w_sp < i_prev.held) begin
            o_next.peak  = w_sp;
            o_next.rms   = w_sr;
            o_next.timer = w_ht;
            o_next.held  = (w_ht == '0) ? sat_drop(i_prev.held, i_item.drop) : i_prev.held;
        end else begin
            o_next.peak  = w_sp;
            o_next.rms   = w_sr;
            o_next.timer = i_cfg.hold_ticks;
            o_next.held  = w_sp;
        end
        o_peak_clip = (o_next.peak >= i_cfg.clip_threshold);
        o_rms_clip  = (o_next.rms >= i_cfg.clip_threshold);
    end

endmodule

>>> design/peak_meter_hold_decay_core.sv
// Peak meter hold and decay core: top level with per-channel state memory.
// Each item passes a stage-one register, then the result register; one item per cycle while the output is not stalled.
// The decay product is formed on entry, the state read is registered, and a
// write-back bypass covers back-to-back items on the same channel.
// Synchronous active-low reset clears the pipeline, seen flags and configuration registers.
// Depends on pmhd_pkg and pmhd_ballistics.
module peak_meter_hold_decay_core #(
    parameter int CHANNELS = pmhd_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmhd_pkg::CH_W-1:0]     i_channel,
    input  logic [pmhd_pkg::LEVEL_W-1:0]  i_peak_level,
    input  logic [pmhd_pkg::LEVEL_W-1:0]  i_rms_level,
    input  logic [pmhd_pkg::TICK_W-1:0]   i_elapsed_ticks,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pmhd_pkg::CH_W-1:0]     o_out_channel,
    output logic [pmhd_pkg::LEVEL_W-1:0]  o_shown_peak_out,
    output logic [pmhd_pkg::LEVEL_W-1:0]  o_shown_rms_out,
    output logic [pmhd_pkg::LEVEL_W-1:0]  o_held_peak_out,
    output logic                          o_peak_clip,
    output logic                          o_rms_clip,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pmhd_pkg::ADDR_W-1:0]   paddr,
    input  logic [pmhd_pkg::DATA_W-1:0]   pwdata,
    output logic [pmhd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import pmhd_pkg::*;

    localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cfg r_cfg;

    logic [PROD_W-1:0] w_prod;
    logic              w_accept;
    logic              w_s1_adv;
    logic              w_wr_en;
    logic              w_first;
    logic [AW-1:0]     w_in_idx;
    logic [AW-1:0]     w_s1_idx;
    t_chan_state       w_prev;
    t_chan_state       w_next;
    logic              w_peak_clip;
    logic              w_rms_clip;

    t_chan_state       r_mem [DEPTH];
    logic [DEPTH-1:0]  r_seen;
    t_chan_state       r_rd_data;
    t_chan_state       r_fwd_data;
    logic              r_fwd_hit;
    logic              r_s1_valid;
    logic              r_s1_in_range;
    logic [CH_W-1:0]   r_s1_channel;
    t_item             r_s1_item;

    logic                r_out_valid;
    logic [CH_W-1:0]     r_out_channel;
    logic [LEVEL_W-1:0]  r_out_peak;
    logic [LEVEL_W-1:0]  r_out_rms;
    logic [LEVEL_W-1:0]  r_out_held;
    logic                r_out_peak_clip;
    logic                r_out_rms_clip;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_per_tick <= DECAY_RST;
            r_cfg.hold_ticks     <= HOLD_RST;
            r_cfg.clip_threshold <= CLIP_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[ADDR_W-1:2])
                REG_DECAY: r_cfg.decay_per_tick <= pwdata[TICK_W-1:0];
                REG_HOLD:  r_cfg.hold_ticks     <= pwdata[TICK_W-1:0];
                REG_CLIP:  r_cfg.clip_threshold <= pwdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_W-1:2])
            REG_DECAY: prdata = DATA_W'(r_cfg.decay_per_tick);
            REG_HOLD:  prdata = DATA_W'(r_cfg.hold_ticks);
            REG_CLIP:  prdata = DATA_W'(r_cfg.clip_threshold);
            default:   prdata = '0;
        endcase
    end

    // Handshake and pipeline control.
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_idx   = i_channel[AW-1:0];
    assign w_s1_idx   = r_s1_channel[AW-1:0];
    assign w_wr_en    = w_s1_adv && r_s1_in_range;
    assign w_prod     = {{TICK_W{1'b0}}, i_elapsed_ticks} * {{TICK_W{1'b0}}, r_cfg.decay_per_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_channel      <= i_channel;
            r_s1_in_range     <= (32'(i_channel) < 32'(CHANNELS));
            r_s1_item.peak    <= i_peak_level;
            r_s1_item.rms     <= i_rms_level;
            r_s1_item.elapsed <= i_elapsed_ticks;
            r_s1_item.drop    <= w_prod[PROD_W-1:DROP_SHIFT];
            r_fwd_hit         <= w_wr_en && (w_s1_idx == w_in_idx);
            r_fwd_data        <= w_next;
        end
    end

    // Channel state memory: one read and one write port.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_mem[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_s1_idx] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_wr_en) begin
            r_seen[w_s1_idx] <= 1'b1;
        end
    end

    assign w_prev  = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign w_first = !(r_s1_in_range && r_seen[w_s1_idx]);

    pmhd_ballistics u_ballistics (
        .i_item      (r_s1_item),
        .i_prev      (w_prev),
        .i_first     (w_first),
        .i_cfg       (r_cfg),
        .o_next      (w_next),
        .o_peak_clip (w_peak_clip),
        .o_rms_clip  (w_rms_clip)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_channel   <= r_s1_channel;
            r_out_peak      <= w_next.peak;
            r_out_rms       <= w_next.rms;
            r_out_held      <= w_next.held;
            r_out_peak_clip <= w_peak_clip;
            r_out_rms_clip  <= w_rms_clip;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_channel;
    assign o_shown_peak_out = r_out_peak;
    assign o_shown_rms_out  = r_out_rms;
    assign o_held_peak_out  = r_out_held;
    assign o_peak_clip      = r_out_peak_clip;
    assign o_rms_clip       = r_out_rms_clip;

endmodule

>>> design/pmhd_checker.sv
// Port-level checks for the peak meter hold and decay core, with its bind.
// Depends on pmhd_pkg and peak_meter_hold_decay_core.
module pmhd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [pmhd_pkg::CH_W-1:0]     o_out_channel,
    input logic [pmhd_pkg::LEVEL_W-1:0]  o_shown_peak_out,
    input logic [pmhd_pkg::LEVEL_W-1:0]  o_shown_rms_out,
    input logic [pmhd_pkg::LEVEL_W-1:0]  o_held_peak_out,
    input logic                          o_peak_clip,
    input logic                          o_rms_clip,
    input logic                          pready
);
    import pmhd_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    // The input side only stalls when a result is waiting and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // An accepted item is followed by a presented result once it has passed the stage-one and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ##1 o_out_valid)
        else $error("no result two cycles after an accepted item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_out_channel) && $stable(o_shown_peak_out) &&
             $stable(o_shown_rms_out) && $stable(o_held_peak_out) &&
             $stable(o_peak_clip) && $stable(o_rms_clip)))
        else $error("stalled result changed");

endmodule

bind peak_meter_hold_decay_core pmhd_checker u_pmhd_checker (.*);
